// File: rtl/rgbc_pkg.sv
// Shared types and constants of the run group bin combiner.
`default_nettype none

package rgbc_pkg;

  localparam int MAX_BINS  = 256;
  localparam int LABEL_W   = 8;
  localparam int MAG_W     = 16;
  localparam int COL_W     = 8;
  localparam int CNT_W     = $clog2(MAX_BINS + 1);
  localparam int LSUM_W    = MAG_W + $clog2(MAX_BINS);
  localparam int CSUM_W    = COL_W + $clog2(MAX_BINS);
  localparam int NCOL      = 3;
  localparam int NLANES    = NCOL + 1;
  localparam int DIV_STEPS = LSUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam int JQ_DEPTH  = 2;
  localparam int JQ_AW     = $clog2(JQ_DEPTH);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_AVG  = 2'd1,
    MODE_ALL  = 2'd2,
    MODE_MAX  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CLOSE,
    FS_BIN
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_HOLD
  } back_state_e;

  typedef enum logic {
    JK_DIRECT,
    JK_AVG
  } job_kind_e;

  typedef struct packed {
    logic [LABEL_W-1:0]              label;
    logic [MAG_W-1:0]                mag;
    logic [NCOL-1:0][COL_W-1:0]      color;
    logic                            fe;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]                count;
    logic [LSUM_W-1:0]               lsum;
    logic [NCOL-1:0][CSUM_W-1:0]     csum;
    logic [MAG_W-1:0]                peak;
    logic [NCOL-1:0][COL_W-1:0]      pcolor;
  } acc_t;

  typedef struct packed {
    job_kind_e                       kind;
    logic [LABEL_W-1:0]              grp;
    logic [CNT_W-1:0]                count;
    logic [LSUM_W-1:0]               lsum;
    logic [NCOL-1:0][CSUM_W-1:0]     csum;
    logic                            done;
  } job_t;

  typedef struct packed {
    logic [LABEL_W-1:0]              grp;
    logic [MAG_W-1:0]                level;
    logic [NCOL-1:0][COL_W-1:0]      color;
    logic                            done;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/rgbc_front.sv
// Front end: takes bins, tracks the open group and issues jobs.
`default_nettype none

module rgbc_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  rgbc_pkg::mode_e       mode_i,
  input  wire                   push_i,
  input  rgbc_pkg::item_t       item_i,
  output logic                  busy_o,
  output logic                  job_push_o,
  output rgbc_pkg::job_t        job_o,
  input  wire                   job_full_i
);

  rgbc_pkg::front_state_e         state_q, state_d;
  rgbc_pkg::item_t                item_q, item_d;
  rgbc_pkg::acc_t                 acc_q, acc_d, acc_next;
  logic [rgbc_pkg::LABEL_W-1:0]   grp_q, grp_d;
  logic [rgbc_pkg::LABEL_W-1:0]   label_q, label_d;
  logic                           active_q, active_d;
  logic                           combine;
  logic                           need_push;

  function automatic rgbc_pkg::job_t close_job(rgbc_pkg::mode_e m,
                                               logic [rgbc_pkg::LABEL_W-1:0] g,
                                               rgbc_pkg::acc_t a, logic d);
    rgbc_pkg::job_t j;
    j = '0;
    j.grp  = g;
    j.done = d;
    if (m == rgbc_pkg::MODE_AVG) begin
      j.kind  = rgbc_pkg::JK_AVG;
      j.count = a.count;
      j.lsum  = a.lsum;
      j.csum  = a.csum;
    end else begin
      j.kind = rgbc_pkg::JK_DIRECT;
      j.lsum = rgbc_pkg::LSUM_W'(a.peak);
      for (int k = 0; k < rgbc_pkg::NCOL; k++) begin
        j.csum[k] = rgbc_pkg::CSUM_W'(a.pcolor[k]);
      end
    end
    return j;
  endfunction

  assign combine = (mode_i == rgbc_pkg::MODE_AVG) || (mode_i == rgbc_pkg::MODE_MAX);
  assign busy_o  = (state_q != rgbc_pkg::FS_IDLE);

  always_comb begin
    acc_next = acc_q;
    if (acc_q.count < rgbc_pkg::CNT_W'(rgbc_pkg::MAX_BINS)) begin
      acc_next.count = acc_q.count + 1'b1;
      acc_next.lsum  = acc_q.lsum + rgbc_pkg::LSUM_W'(item_q.mag);
      for (int k = 0; k < rgbc_pkg::NCOL; k++) begin
        acc_next.csum[k] = acc_q.csum[k] + rgbc_pkg::CSUM_W'(item_q.color[k]);
      end
    end
    if (item_q.mag > acc_q.peak) begin
      acc_next.peak   = item_q.mag;
      acc_next.pcolor = item_q.color;
    end
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    acc_d      = acc_q;
    grp_d      = grp_q;
    label_d    = label_q;
    active_d   = active_q;
    job_push_o = 1'b0;
    job_o      = '0;
    need_push  = 1'b0;
    unique case (state_q)
      rgbc_pkg::FS_IDLE: begin
        if (push_i) begin
          item_d  = item_i;
          state_d = rgbc_pkg::FS_CLOSE;
        end
      end
      rgbc_pkg::FS_CLOSE: begin
        if (active_q && (item_q.label != label_q)) begin
          need_push = combine;
          job_o     = close_job(mode_i, grp_q, acc_q, 1'b0);
          if (!need_push || !job_full_i) begin
            job_push_o = need_push;
            grp_d      = grp_q + 1'b1;
            acc_d      = '0;
            state_d    = rgbc_pkg::FS_BIN;
          end
        end else begin
          state_d = rgbc_pkg::FS_BIN;
        end
      end
      rgbc_pkg::FS_BIN: begin
        if (combine) begin
          need_push = item_q.fe;
          job_o     = close_job(mode_i, grp_q, acc_next, 1'b1);
        end else begin
          need_push  = 1'b1;
          job_o.kind = rgbc_pkg::JK_DIRECT;
          job_o.grp  = (mode_i == rgbc_pkg::MODE_NONE) ? item_q.label : grp_q;
          job_o.lsum = rgbc_pkg::LSUM_W'(item_q.mag);
          for (int k = 0; k < rgbc_pkg::NCOL; k++) begin
            job_o.csum[k] = rgbc_pkg::CSUM_W'(item_q.color[k]);
          end
          job_o.done = item_q.fe;
        end
        if (!need_push || !job_full_i) begin
          job_push_o = need_push;
          state_d    = rgbc_pkg::FS_IDLE;
          if (item_q.fe) begin
            active_d = 1'b0;
            label_d  = '0;
            grp_d    = '0;
            acc_d    = '0;
          end else begin
            active_d = 1'b1;
            label_d  = item_q.label;
            acc_d    = acc_next;
          end
        end
      end
      default: state_d = rgbc_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rgbc_pkg::FS_IDLE;
      acc_q    <= '0;
      grp_q    <= '0;
      label_q  <= '0;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      grp_q    <= grp_d;
      label_q  <= label_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  a_idle_no_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rgbc_pkg::FS_IDLE) |-> !job_push_o)
    else $error("job issued with no bin in hand");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q.count <= rgbc_pkg::CNT_W'(rgbc_pkg::MAX_BINS))
    else $error("member count beyond limit");

endmodule

`default_nettype wire

// File: rtl/rgbc_job_fifo.sv
// Short job queue between the front and back ends.
`default_nettype none

module rgbc_job_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  rgbc_pkg::job_t        job_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  valid_o,
  output rgbc_pkg::job_t        job_o
);

  rgbc_pkg::job_t               mem_q [rgbc_pkg::JQ_DEPTH];
  logic [rgbc_pkg::JQ_AW-1:0]   wr_q, rd_q;
  logic [rgbc_pkg::JQ_AW:0]     cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (rgbc_pkg::JQ_AW + 1)'(rgbc_pkg::JQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into full queue");

endmodule

`default_nettype wire

// File: rtl/rgbc_back.sv
// Back end: carries out jobs, divides group sums, holds the result.
`default_nettype none

module rgbc_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   job_valid_i,
  input  rgbc_pkg::job_t        job_i,
  output logic                  job_pop_o,
  output logic                  res_valid_o,
  output rgbc_pkg::res_t        res_o,
  input  wire                   pop_i
);

  rgbc_pkg::back_state_e         state_q, state_d;
  rgbc_pkg::res_t                out_q, out_d;
  logic                          out_valid_q;
  logic                          out_load, out_free, div_load, div_step;
  logic [rgbc_pkg::CNT_W-1:0]    rem_q [rgbc_pkg::NLANES];
  logic [rgbc_pkg::CNT_W-1:0]    rem_d [rgbc_pkg::NLANES];
  logic [rgbc_pkg::LSUM_W-1:0]   quo_q [rgbc_pkg::NLANES];
  logic [rgbc_pkg::LSUM_W-1:0]   quo_d [rgbc_pkg::NLANES];
  logic [rgbc_pkg::CNT_W:0]      trial [rgbc_pkg::NLANES];
  logic [rgbc_pkg::CNT_W-1:0]    div_q;
  logic [rgbc_pkg::DIV_CW-1:0]   cnt_q;
  logic [rgbc_pkg::LABEL_W-1:0]  grp_q;
  logic                          done_q;

  assign out_free    = !out_valid_q || pop_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    for (int k = 0; k < rgbc_pkg::NLANES; k++) begin
      trial[k] = {rem_q[k], quo_q[k][rgbc_pkg::LSUM_W-1]};
      if (trial[k] >= {1'b0, div_q}) begin
        rem_d[k] = rgbc_pkg::CNT_W'(trial[k] - {1'b0, div_q});
        quo_d[k] = {quo_q[k][rgbc_pkg::LSUM_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rgbc_pkg::CNT_W'(trial[k]);
        quo_d[k] = {quo_q[k][rgbc_pkg::LSUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    div_load  = 1'b0;
    div_step  = 1'b0;
    out_d     = '0;
    unique case (state_q)
      rgbc_pkg::BS_IDLE: begin
        out_d.grp  = job_i.grp;
        out_d.done = job_i.done;
        if (job_i.kind == rgbc_pkg::JK_DIRECT) begin
          out_d.level = job_i.lsum[rgbc_pkg::MAG_W-1:0];
          for (int k = 0; k < rgbc_pkg::NCOL; k++) begin
            out_d.color[k] = job_i.csum[k][rgbc_pkg::COL_W-1:0];
          end
        end
        if (job_valid_i) begin
          if ((job_i.kind == rgbc_pkg::JK_AVG) && (job_i.count != '0)) begin
            job_pop_o = 1'b1;
            div_load  = 1'b1;
            state_d   = rgbc_pkg::BS_DIV;
          end else if (out_free) begin
            job_pop_o = 1'b1;
            out_load  = 1'b1;
          end
        end
      end
      rgbc_pkg::BS_DIV: begin
        div_step = 1'b1;
        if (cnt_q == rgbc_pkg::DIV_CW'(rgbc_pkg::DIV_STEPS - 1)) begin
          state_d = rgbc_pkg::BS_HOLD;
        end
      end
      rgbc_pkg::BS_HOLD: begin
        out_d.grp   = grp_q;
        out_d.done  = done_q;
        out_d.level = quo_q[0][rgbc_pkg::MAG_W-1:0];
        for (int k = 0; k < rgbc_pkg::NCOL; k++) begin
          out_d.color[k] = quo_q[k+1][rgbc_pkg::COL_W-1:0];
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = rgbc_pkg::BS_IDLE;
        end
      end
      default: state_d = rgbc_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgbc_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
    if (div_load) begin
      div_q    <= job_i.count;
      grp_q    <= job_i.grp;
      done_q   <= job_i.done;
      cnt_q    <= '0;
      quo_q[0] <= job_i.lsum;
      for (int k = 0; k < rgbc_pkg::NCOL; k++) begin
        quo_q[k+1] <= rgbc_pkg::LSUM_W'(job_i.csum[k]);
      end
      for (int k = 0; k < rgbc_pkg::NLANES; k++) begin
        rem_q[k] <= '0;
      end
    end else if (div_step) begin
      cnt_q <= cnt_q + 1'b1;
      for (int k = 0; k < rgbc_pkg::NLANES; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rgbc_pkg::BS_DIV) |-> (div_q != '0))
    else $error("division by zero member count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> pop_i)
    else $error("waiting result overwritten");

endmodule

`default_nettype wire

// File: rtl/run_group_bin_combiner.sv
// Top level of the run group bin combiner.
// Usage:
//   Input queue side: drive a bin on column_label_i .. frame_end_i and raise
//   push; a transfer takes place on a clock edge with push high and full low.
//   Result queue side: while empty is low the oldest result is on the result
//   ports; raise pop to take it. mode_we_i writes mode_i (0 none, 1 average,
//   2 relabel all, 3 maximum); write it only while the block is idle.
// Flow:
//   The front end takes each bin through accept, group close and accumulate
//   in turn and takes no new bin until it is done with the last. Results go
//   through the job queue and the back end's output register; a group closed
//   by a label change is issued from the group close step. An average result
//   goes through a 24-step shift-subtract divider for the level and the three
//   color sums in parallel; the back end takes no new job until it has handed
//   on the quotients. A 2-entry job queue lets the front end keep taking bins
//   while the divider runs; the front stalls only when that queue is full.
// Reset: clears the mode to none, the open group, the queue and the result.
// Stall: when pop stays low the result holds, the back end stops at its
//   next output, the job queue fills and then full stays high.
`default_nettype none

module run_group_bin_combiner (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         mode_we_i,
  input  wire  [1:0]  mode_i,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  column_label_i,
  input  wire  [15:0] magnitude_i,
  input  wire  [7:0]  red_in_i,
  input  wire  [7:0]  green_in_i,
  input  wire  [7:0]  blue_in_i,
  input  wire         frame_end_i,
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  group_number_o,
  output logic [15:0] level_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        frame_done_o
);

  rgbc_pkg::mode_e   mode_q;
  rgbc_pkg::item_t   item;
  rgbc_pkg::job_t    fr_job, bk_job;
  rgbc_pkg::res_t    res;
  logic              fr_push, jq_full, jq_valid, bk_pop, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rgbc_pkg::MODE_NONE;
    end else if (mode_we_i) begin
      mode_q <= rgbc_pkg::mode_e'(mode_i);
    end
  end

  assign item.label    = column_label_i;
  assign item.mag      = magnitude_i;
  assign item.color[0] = red_in_i;
  assign item.color[1] = green_in_i;
  assign item.color[2] = blue_in_i;
  assign item.fe       = frame_end_i;

  rgbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .push_i     (push),
    .item_i     (item),
    .busy_o     (full),
    .job_push_o (fr_push),
    .job_o      (fr_job),
    .job_full_i (jq_full)
  );

  rgbc_job_fifo u_jq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .job_i   (fr_job),
    .full_o  (jq_full),
    .pop_i   (bk_pop),
    .valid_o (jq_valid),
    .job_o   (bk_job)
  );

  rgbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (jq_valid),
    .job_i       (bk_job),
    .job_pop_o   (bk_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .pop_i       (pop)
  );

  assign empty          = !res_valid;
  assign group_number_o = res.grp;
  assign level_o        = res.level;
  assign red_out_o      = res.color[0];
  assign green_out_o    = res.color[1];
  assign blue_out_o     = res.color[2];
  assign frame_done_o   = res.done;

endmodule

`default_nettype wire
